/* rtl/core/bchash_pkg.sv */
// ----------------------------------------------------------------------------
// bchash_pkg: shared types and constants of the bipartition hash table
// Payload structs, result status codes, controller command and status bundles.
// ----------------------------------------------------------------------------
package bchash_pkg;

  // Default sizes of the table
  localparam int BUCKETS_DEF = 1024;
  localparam int WAYS_DEF    = 4;
  localparam int TAXA_DEF    = 64;

  // Fixed field widths
  localparam int ACT_W     = 1;
  localparam int TREE_W    = 10;
  localparam int BKT_IN_W  = 10;
  localparam int KEY_W     = 32;
  localparam int BITS_W    = 64;
  localparam int CNT_W     = 11;
  localparam int STATUS_W  = 3;
  localparam int BKT_IN_SPAN = 1 << BKT_IN_W;

  localparam logic [CNT_W-1:0] NUM_TREES_RST = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_MAX       = '1;

  localparam logic ACT_PROCESS = 1'b0;
  localparam logic ACT_CLEAR   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_COUNTED   = 3'd1,
    ST_NOMATCH   = 3'd2,
    ST_CONSENSUS = 3'd3,
    ST_NOTCONS   = 3'd4,
    ST_FULL      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [TREE_W-1:0]   tree_index;
    logic [BKT_IN_W-1:0] bucket;
    logic [KEY_W-1:0]    key;
    logic [BITS_W-1:0]   bipartition;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [BITS_W-1:0]   consensus_bits;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;   // capture accepted input beat
    logic load_idx;  // capture reduced bucket index
    logic mem_rd;    // read the bucket row
    logic sweep_we;  // write an empty row at the sweep address
    logic commit;    // write back the bucket row of a process item and load the result
  } bchash_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_clear;  // held item is a clear action
    logic sweep_last;  // sweep address is at the last bucket
  } bchash_sts_t;

endpackage

/* rtl/core/bchash_ctrl.sv */
// ----------------------------------------------------------------------------
// bchash_ctrl: sequencer of the bipartition hash table
// Steps each item through index reduction, row read and write back, and runs
// the row-clearing sweep after reset and for a clear action.
// ----------------------------------------------------------------------------
module bchash_ctrl
  import bchash_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  bchash_sts_t sts,
  output bchash_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MOD   = 6'b000100,
    S_READ  = 6'b001000,
    S_SWEEP = 6'b010000,
    S_EVAL  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.sweep_we = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MOD;
        end
      end
      S_MOD: begin
        cmd.load_idx = 1'b1;
        state_nxt    = sts.item_clear ? S_SWEEP : S_READ;
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_EVAL;
      end
      S_SWEEP: begin
        cmd.sweep_we = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // hold the result until taken, set it on commit
  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/bchash_dp.sv */
// ----------------------------------------------------------------------------
// bchash_dp: datapath of the bipartition hash table
// Bucket row memory, bucket index reduction, parallel key compare, count
// update, insert and result register.
// ----------------------------------------------------------------------------
module bchash_dp
  import bchash_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF,
  parameter int TAXA    = TAXA_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  bchash_cmd_t      cmd,
  output bchash_sts_t      sts,
  output out_item_t        out_data
);

  localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int FW     = $clog2(WAYS + 1);
  localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W  = KEY_W + CNT_W + TAXA;
  localparam int ROW_W  = FW + WAYS * ENT_W;
  localparam int CNT_LSB = TAXA;
  localparam int KEY_LSB = TAXA + CNT_W;

  in_item_t          item_r;
  logic [BW-1:0]     idx_r;
  logic [BW-1:0]     bkt_mod;
  logic [BW-1:0]     sweep_cnt_r, sweep_cnt_nxt;
  logic              sweep_last;
  logic [CNT_W-1:0]  num_trees_r;
  logic [ROW_W-1:0]  mem [BUCKETS];
  logic [ROW_W-1:0]  rd_row_r;
  logic [ROW_W-1:0]  new_row;
  logic [ROW_W-1:0]  wr_row;
  logic [BW-1:0]     wr_addr;
  logic              mem_we;
  out_item_t         res;
  out_item_t         out_data_r;

  // ---------------- bucket index reduction ----------------
  generate
    if (BUCKETS >= BKT_IN_SPAN) begin : g_direct
      assign bkt_mod = BW'(item_r.bucket);
    end else begin : g_recip
      // floor(b / BUCKETS) by reciprocal, exact for every 10-bit b
      localparam int    RSH   = 2 * BKT_IN_W;
      localparam int    RCP_W = RSH + 1;
      localparam int    PRD_W = BKT_IN_W + RCP_W;
      localparam longint RECIP = ((64'd1 << RSH) + BUCKETS - 1) / BUCKETS;

      logic [PRD_W-1:0]    prod_r;
      logic [BKT_IN_W-1:0] quot;
      logic [BKT_IN_W-1:0] rem;

      always_ff @(posedge clk) begin
        if (cmd.load_in) begin
          prod_r <= PRD_W'(in_data.bucket) * PRD_W'(RECIP);
        end
      end

      assign quot    = BKT_IN_W'(prod_r[PRD_W-1:RSH]);
      assign rem     = item_r.bucket - quot * BKT_IN_W'(BUCKETS);
      assign bkt_mod = rem[BW-1:0];
    end
  endgenerate

  // ---------------- item, index and config registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_data;
    end
    if (cmd.load_idx) begin
      idx_r <= bkt_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_trees_r <= NUM_TREES_RST;
      sweep_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        num_trees_r <= cfg_data;
      end
      sweep_cnt_r <= sweep_cnt_nxt;
    end
  end

  // ---------------- clearing sweep ----------------
  assign sweep_last = (sweep_cnt_r == BW'(BUCKETS - 1));

  always_comb begin
    sweep_cnt_nxt = sweep_cnt_r;
    if (cmd.sweep_we) begin
      sweep_cnt_nxt = sweep_last ? '0 : sweep_cnt_r + 1'b1;
    end
  end

  assign sts.sweep_last = sweep_last;
  assign sts.item_clear = (item_r.action == ACT_CLEAR);

  // ---------------- row memory ----------------
  assign mem_we  = cmd.sweep_we || (cmd.commit && (item_r.action == ACT_PROCESS));
  assign wr_addr = cmd.sweep_we ? sweep_cnt_r : idx_r;
  assign wr_row  = cmd.sweep_we ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd.mem_rd) begin
      rd_row_r <= mem[idx_r];
    end
  end

  // ---------------- lookup and update ----------------
  always_comb begin
    logic [FW-1:0]     fill;
    logic [WAYS-1:0]   match;
    logic              hit;
    logic [WW-1:0]     hit_w;
    logic [CNT_W-1:0]  nt;
    logic [CNT_W-1:0]  nt_m1;
    logic [CNT_W-1:0]  hit_cnt;
    logic [TAXA-1:0]   hit_bits;
    logic [ENT_W-1:0]  ent;
    logic [ENT_W-1:0]  new_ent;

    fill     = rd_row_r[ROW_W-1 -: FW];
    hit      = 1'b0;
    hit_w    = '0;
    hit_cnt  = '0;
    hit_bits = '0;
    new_row  = rd_row_r;
    res      = '{status: ST_NOMATCH, consensus_bits: '0};
    nt       = (num_trees_r < NUM_TREES_RST) ? NUM_TREES_RST : num_trees_r;
    nt_m1    = nt - 1'b1;
    new_ent  = {item_r.key, CNT_W'(1), item_r.bipartition[TAXA-1:0]};

    // compare all valid ways, first match wins
    for (int w = 0; w < WAYS; w++) begin
      ent      = rd_row_r[w*ENT_W +: ENT_W];
      match[w] = (FW'(w) < fill) && (ent[KEY_LSB +: KEY_W] == item_r.key);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit      = 1'b1;
        hit_w    = WW'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      ent = rd_row_r[w*ENT_W +: ENT_W];
      if (hit_w == WW'(w)) begin
        hit_cnt  = ent[CNT_LSB +: CNT_W];
        hit_bits = ent[TAXA-1:0];
      end
    end

    if (item_r.action == ACT_CLEAR) begin
      res.status = ST_CLEARED;
    end else if (item_r.tree_index == '0) begin
      if (fill >= FW'(WAYS)) begin
        res.status = ST_FULL;
      end else begin
        res.status = ST_INSERTED;
        for (int w = 0; w < WAYS; w++) begin
          if (fill == FW'(w)) begin
            new_row[w*ENT_W +: ENT_W] = new_ent;
          end
        end
        new_row[ROW_W-1 -: FW] = fill + 1'b1;
      end
    end else if (CNT_W'(item_r.tree_index) < nt_m1) begin
      if (hit) begin
        res.status = ST_COUNTED;
        for (int w = 0; w < WAYS; w++) begin
          if (hit_w == WW'(w) && hit_cnt != CNT_MAX) begin
            new_row[w*ENT_W + CNT_LSB +: CNT_W] = hit_cnt + 1'b1;
          end
        end
      end
    end else begin
      if (hit) begin
        if (hit_cnt == nt_m1) begin
          res.status         = ST_CONSENSUS;
          res.consensus_bits = BITS_W'(hit_bits);
        end else begin
          res.status = ST_NOTCONS;
        end
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  assign out_data = out_data_r;

endmodule

/* rtl/core/bipartition_consensus_hash_table_core.sv */
// ----------------------------------------------------------------------------
// bipartition_consensus_hash_table_core: bucketed bipartition counting table
// Counts bipartitions over a tree collection and reports consensus ones.
// ----------------------------------------------------------------------------
// Sequence: an accepted input beat goes through index reduction, row read, then
//   compare and write back, which loads the result register; a clear sweeps
//   every row, one row emptied per cycle, in place of the read. Write back waits
//   while a held result is stalled; no new item is taken before that.
// Reset: synchronous, active low; afterwards a sweep empties every bucket while
//   in_stall stays high. num_trees resets to 2.
// ----------------------------------------------------------------------------
module bipartition_consensus_hash_table_core
  import bchash_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF,
  parameter int TAXA    = TAXA_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  // num_trees write port
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  bchash_cmd_t cmd;
  bchash_sts_t sts;
  logic        cfg_we;

  // Config writes must land only while idle; the user keeps to this, the block itself does not enforce it.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Sequencer: steps each beat through reduce, read and write back, and
  // drives the row-clearing sweep after reset and on a clear action.
  bchash_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: one memory row per bucket holds the fill level and all ways,
  // so one read gives every candidate entry for the parallel key compare.
  bchash_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .TAXA    (TAXA)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for bipartition_consensus_hash_table_core
// Walks a directed table of beats, then runs random tree collections with
// noise. Every result beat is checked against a hand-typed result or a local
// model of the bucket table, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import bchash_pkg::*;

  localparam int NSLOT = BUCKETS_DEF * WAYS_DEF;
  localparam logic [BITS_W-1:0] TAXA_MASK = {BITS_W{1'b1}} >> (BITS_W - TAXA_DEF);

  // One row of the directed table: either a num_trees write or an item beat.
  // Rows with typed set carry their result by hand; the rest use the model.
  typedef struct {
    bit               is_cfg;
    logic [CNT_W-1:0] cfg_val;
    in_item_t         item;
    bit               typed;
    out_item_t        want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  // Local copy of the bucket table and the num_trees register
  logic [KEY_W-1:0]  slot_key [NSLOT];
  logic [CNT_W-1:0]  slot_cnt [NSLOT];
  logic [BITS_W-1:0] slot_bits[NSLOT];
  int                fill_lvl [BUCKETS_DEF];
  logic [CNT_W-1:0]  trees_cfg = NUM_TREES_RST;

  dir_row_t  dir_rows[$];
  out_item_t result_q[$];
  int        bad_beats = 0;
  int        beats_sent = 0;
  bit        idle_on = 1'b1;

  always #5 clk = ~clk;

  bipartition_consensus_hash_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Apply one item to the table copy and return the result it earns.
  function automatic out_item_t hash_predict(input in_item_t it);
    out_item_t r;
    int        b;
    int        base;
    int        w;
    int        hit;
    int        eff;
    r.status = ST_INSERTED;
    r.consensus_bits = '0;
    b = int'(it.bucket) % BUCKETS_DEF;
    base = b * WAYS_DEF;
    // num_trees below 2 behaves as 2
    eff = (trees_cfg < 2) ? 2 : int'(trees_cfg);
    if (it.action == ACT_CLEAR) begin
      // entries stay put but become unreachable
      foreach (fill_lvl[i]) fill_lvl[i] = 0;
      r.status = ST_CLEARED;
    end else if (it.tree_index == '0) begin
      if (fill_lvl[b] >= WAYS_DEF) begin
        r.status = ST_FULL;
      end else begin
        slot_key[base + fill_lvl[b]]  = it.key;
        slot_cnt[base + fill_lvl[b]]  = CNT_W'(1);
        slot_bits[base + fill_lvl[b]] = it.bipartition & TAXA_MASK;
        fill_lvl[b]++;
        r.status = ST_INSERTED;
      end
    end else begin
      // first matching way wins, duplicates behind it are never touched
      hit = -1;
      for (w = 0; w < fill_lvl[b]; w++) begin
        if (hit < 0 && slot_key[base + w] == it.key) hit = w;
      end
      if (hit < 0) begin
        r.status = ST_NOMATCH;
      end else if (int'(it.tree_index) < eff - 1) begin
        if (slot_cnt[base + hit] != CNT_MAX) slot_cnt[base + hit]++;
        r.status = ST_COUNTED;
      end else if (int'(slot_cnt[base + hit]) == eff - 1) begin
        r.status = ST_CONSENSUS;
        r.consensus_bits = slot_bits[base + hit];
      end else begin
        r.status = ST_NOTCONS;
      end
    end
    return r;
  endfunction

  function automatic in_item_t mk_item(input logic act, input logic [TREE_W-1:0] tree,
                                       input logic [BKT_IN_W-1:0] bkt,
                                       input logic [KEY_W-1:0] key,
                                       input logic [BITS_W-1:0] bits);
    in_item_t it;
    it.action      = act;
    it.tree_index  = tree;
    it.bucket      = bkt;
    it.key         = key;
    it.bipartition = bits;
    return it;
  endfunction

  function automatic dir_row_t item_row(input in_item_t it, input bit typed,
                                        input status_t st, input logic [BITS_W-1:0] cb);
    dir_row_t row;
    row.is_cfg  = 1'b0;
    row.cfg_val = '0;
    row.item    = it;
    row.typed   = typed;
    row.want.status = st;
    row.want.consensus_bits = cb;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CNT_W-1:0] v);
    dir_row_t row;
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    row.item    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  // Append one row to the end of the directed table.
  function automatic void add_row(input dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Drive one input beat after a random gap, hold it until taken, then
  // queue its expected result.
  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t hand_res);
    int        gap;
    bit        taken;
    out_item_t pred;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pred = hash_predict(it);
    result_q.insert(result_q.size(), typed ? hand_res : pred);
    beats_sent++;
  endtask

  // Write num_trees only once every pending result is back.
  task automatic write_num_trees(input logic [CNT_W-1:0] v);
    bit taken;
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    trees_cfg = v;
  endtask

  // Random beat near a pool bucket and key; rarely a clear.
  task automatic send_noise(input logic [BKT_IN_W-1:0] near_bkt,
                            input logic [KEY_W-1:0] near_key);
    in_item_t it;
    it.action      = ($urandom_range(0, 199) == 0) ? ACT_CLEAR : ACT_PROCESS;
    it.tree_index  = ($urandom_range(0, 2) == 0) ? '0 : TREE_W'($urandom);
    it.bucket      = $urandom_range(0, 1) ? near_bkt : BKT_IN_W'($urandom);
    it.key         = $urandom_range(0, 1) ? near_key : $urandom;
    it.bipartition = {$urandom, $urandom};
    send_beat(it, 1'b0, '0);
  endtask

  task automatic note_bad(input string what, input out_item_t want, input out_item_t got);
    bad_beats++;
    if (bad_beats <= 10) begin
      $display("%0t: %s: status exp %0d got %0d, bits exp %h got %h", $realtime, what,
               want.status, got.status, want.consensus_bits, got.consensus_bits);
    end
  endtask

  // Result side: sample at the falling edge so the beat seen is the one
  // taken at the next rising edge, then draw a fresh stall for the next beat.
  initial begin : drain
    int        hold;
    bit        take;
    out_item_t got;
    out_item_t want;
    hold = 0;
    forever begin
      @(negedge clk);
      take = rst_n && out_valid && !out_stall;
      if (take) begin
        got = out_data;
        if (result_q.size() == 0) begin
          note_bad("result beat with nothing pending", '0, got);
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status || got.consensus_bits !== want.consensus_bits)
            note_bad("result mismatch", want, got);
        end
      end
      @(posedge clk);
      if (take) hold = idle_on ? $urandom_range(0, 17) : 0;
      out_stall <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0]  ka, kb, kc, kd;
    logic [BITS_W-1:0] bx, by;
    logic [CNT_W-1:0]  ntv;
    logic [BKT_IN_W-1:0] pool_bkt[3];
    logic [BKT_IN_W-1:0] key_bkt[8];
    logic [KEY_W-1:0]  pool_key[8];
    logic [BITS_W-1:0] pool_bits[8];
    int                eff, mid_hi, last_tree, n_keys, n_bkts, j, rand_start;

    ka = 32'hA5A5_0001;
    kb = 32'h5A5A_0002;
    kc = 32'h0F0F_0003;
    kd = 32'hF0F0_0004;
    bx = 64'h0123_4567_89AB_CDEF;
    by = 64'hFEDC_BA98_7654_3210;

    // Hold reset, then let the clearing sweep run under in_stall
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; num_trees is still at its reset value of 2, so every
    // nonzero tree takes the last-tree path until the first write below.
    add_row(item_row(mk_item(ACT_PROCESS, 0, 0, 0, 0), 1, ST_INSERTED, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 0, '1, '1, '1), 1, ST_INSERTED, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 1, '1, '1, 0), 1, ST_CONSENSUS, '1));
    // tree index far past the last still reports
    add_row(item_row(mk_item(ACT_PROCESS, '1, 0, 0, '1), 1, ST_CONSENSUS, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 1, 0, 1, 0), 1, ST_NOMATCH, 0));
    // fill bucket 5 with a duplicate key, then overflow it
    add_row(item_row(mk_item(ACT_PROCESS, 0, 5, ka, bx), 1, ST_INSERTED, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 0, 5, ka, by), 1, ST_INSERTED, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 0, 5, kb, by), 1, ST_INSERTED, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 0, 5, kc, bx), 1, ST_INSERTED, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 0, 5, kd, by), 1, ST_FULL, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 1, 5, ka, 0), 0, ST_CONSENSUS, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 1, 5, kd, 0), 1, ST_NOMATCH, 0));
    // clear ignores every other field
    add_row(item_row(mk_item(ACT_CLEAR, '1, '1, '1, '1), 1, ST_CLEARED, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 1, 5, ka, 0), 1, ST_NOMATCH, 0));
    // four trees: count up to three and report on the last
    add_row(cfg_row(4));
    add_row(item_row(mk_item(ACT_PROCESS, 0, 7, ka, bx), 1, ST_INSERTED, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 1, 7, ka, 0), 1, ST_COUNTED, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 3, 7, ka, 0), 1, ST_NOTCONS, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 2, 7, ka, 0), 1, ST_COUNTED, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 3, 7, ka, 0), 1, ST_CONSENSUS, bx));
    // zero and one behave as two trees
    add_row(cfg_row(0));
    add_row(item_row(mk_item(ACT_PROCESS, 1, 7, ka, 0), 1, ST_NOTCONS, 0));
    add_row(cfg_row(1));
    add_row(item_row(mk_item(ACT_PROCESS, 0, 9, kb, by), 1, ST_INSERTED, 0));
    add_row(item_row(mk_item(ACT_PROCESS, 2, 9, kb, 0), 0, ST_CONSENSUS, 0));
    // with 2047 trees no tree index reaches the last-tree path
    add_row(cfg_row('1));
    add_row(item_row(mk_item(ACT_PROCESS, '1, 9, kb, 0), 1, ST_COUNTED, 0));
    add_row(item_row(mk_item(ACT_CLEAR, 0, 0, 0, 0), 1, ST_CLEARED, 0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_num_trees(dir_rows[i].cfg_val);
      else
        send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random tree collections: each phase picks num_trees, inserts a pool of
    // bipartitions from tree 0, counts them over the middle trees and asks
    // for consensus on the last, with noise beats mixed in.
    rand_start = beats_sent;
    while (beats_sent - rand_start < 400) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 4))
          0:       ntv = 0;
          1:       ntv = 1;
          2:       ntv = 2;
          3:       ntv = 1024;
          default: ntv = '1;
        endcase
      end else begin
        ntv = CNT_W'($urandom_range(2, 7));
      end
      write_num_trees(ntv);
      if ($urandom_range(0, 2) == 0)
        send_beat(mk_item(ACT_CLEAR, TREE_W'($urandom), BKT_IN_W'($urandom), $urandom,
                          {$urandom, $urandom}), 0, '0);

      eff = (ntv < 2) ? 2 : int'(ntv);
      mid_hi = (eff - 2 < 6) ? eff - 2 : 6;
      if (eff - 1 > 1023)
        last_tree = 1023;
      else if ($urandom_range(0, 3) == 0)
        last_tree = $urandom_range(eff - 1, 1023);
      else
        last_tree = eff - 1;

      // few buckets per phase so they fill up and overflow
      n_bkts = $urandom_range(1, 3);
      n_keys = $urandom_range(2, 8);
      for (int b = 0; b < n_bkts; b++) pool_bkt[b] = BKT_IN_W'($urandom);
      for (int k = 0; k < n_keys; k++) begin
        if (k > 0 && $urandom_range(0, 5) == 0) begin
          // same key in the same bucket: only the first copy counts
          j = $urandom_range(0, k - 1);
          pool_key[k] = pool_key[j];
          key_bkt[k]  = key_bkt[j];
        end else begin
          pool_key[k] = $urandom;
          key_bkt[k]  = pool_bkt[$urandom_range(0, n_bkts - 1)];
        end
        pool_bits[k] = {$urandom, $urandom};
      end

      for (int k = 0; k < n_keys; k++) begin
        send_beat(mk_item(ACT_PROCESS, 0, key_bkt[k], pool_key[k], pool_bits[k]), 0, '0);
        if ($urandom_range(0, 9) == 0) send_noise(key_bkt[k], pool_key[k]);
      end
      for (int t = 1; t <= mid_hi; t++) begin
        for (int k = 0; k < n_keys; k++) begin
          // drop some bipartitions from some trees so not all reach consensus
          if ($urandom_range(0, 6) != 0)
            send_beat(mk_item(ACT_PROCESS, t, key_bkt[k], pool_key[k],
                              {$urandom, $urandom}), 0, '0);
          if ($urandom_range(0, 9) == 0) send_noise(key_bkt[k], pool_key[k]);
        end
      end
      for (int k = 0; k < n_keys; k++) begin
        if ($urandom_range(0, 9) != 0)
          send_beat(mk_item(ACT_PROCESS, last_tree, key_bkt[k], pool_key[k],
                            {$urandom, $urandom}), 0, '0);
        if ($urandom_range(0, 9) == 0) send_noise(key_bkt[k], pool_key[k]);
      end
    end

    // Drain: drop valid, wait for every pending result, then a short settle
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_beats == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, clears and sweep included
  initial begin : watchdog
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
